>>> hw/rtl/olmss_pkg.sv
// Shared types, register codes and the slew function of the startup sequencer.
package olmss_pkg;

   localparam int ANGLE_W   = 13;
   localparam int CUR_W     = 16;
   localparam int LIMIT_W   = 15;
   localparam int COUNT_W   = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_REVERSE_DIR   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_TARGET_STEP   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_STEP_DIVIDER  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_HOLD_TICKS    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_ACCEL_TICKS   = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_ALIGN_ANGLE   = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_ALIGN_CURRENT = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_RAMP_STEP     = 3'd7;

   // Stage codes
   localparam logic [1:0] ST_ALIGN_RAMP = 2'd0;
   localparam logic [1:0] ST_ALIGN_HOLD = 2'd1;
   localparam logic [1:0] ST_RAMP       = 2'd2;
   localparam logic [1:0] ST_RUN        = 2'd3;

   typedef struct packed {
      logic                 reverse_dir;
      logic [ANGLE_W-1:0]   target_step;
      logic [COUNT_W-1:0]   step_divider;
      logic [COUNT_W-1:0]   hold_ticks;
      logic [COUNT_W-1:0]   accel_ticks;
      logic [ANGLE_W-1:0]   align_angle;
      logic [LIMIT_W-1:0]   align_current;
      logic [LIMIT_W-1:0]   ramp_step;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      reverse_dir:   1'b0,
      target_step:   13'd1,
      step_divider:  16'd1,
      hold_ticks:    16'd3000,
      accel_ticks:   16'd100,
      align_angle:   13'd0,
      align_current: 15'd2048,
      ramp_step:     15'd4
   };

   typedef struct packed {
      logic [1:0]               phase;
      logic signed [CUR_W-1:0]  iq_ref;
      logic signed [CUR_W-1:0]  id_ref;
      logic [ANGLE_W-1:0]       forced_angle;
   } result_type;

   // Move cur toward tgt by at most step; a zero step jumps to the target.
   function automatic logic signed [CUR_W-1:0] slew(
      input logic signed [CUR_W-1:0] cur,
      input logic signed [CUR_W-1:0] tgt,
      input logic [LIMIT_W-1:0]      step
   );
      logic signed [CUR_W:0] diff;
      logic signed [CUR_W:0] stp;
      logic signed [CUR_W:0] sum;
      diff = CUR_W'(0) + (17'(signed'(tgt)) - 17'(signed'(cur)));
      stp  = signed'({2'b00, step});
      if (step == '0) begin
         slew = tgt;
      end else if (diff > stp) begin
         sum  = 17'(signed'(cur)) + stp;
         slew = sum[CUR_W-1:0];
      end else if (diff < -stp) begin
         sum  = 17'(signed'(cur)) - stp;
         slew = sum[CUR_W-1:0];
      end else begin
         slew = tgt;
      end
   endfunction

endpackage

>>> hw/rtl/olmss_csr.sv
// Configuration register bank of the startup sequencer.
module olmss_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [olmss_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [olmss_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output olmss_pkg::cfg_type                 cfg
);
   import olmss_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_REVERSE_DIR:   cfg_in.reverse_dir   = csr_wdata[0];
            CSR_TARGET_STEP:   cfg_in.target_step   = csr_wdata[ANGLE_W-1:0];
            CSR_STEP_DIVIDER:  cfg_in.step_divider  = csr_wdata;
            CSR_HOLD_TICKS:    cfg_in.hold_ticks    = csr_wdata;
            CSR_ACCEL_TICKS:   cfg_in.accel_ticks   = csr_wdata;
            CSR_ALIGN_ANGLE:   cfg_in.align_angle   = csr_wdata[ANGLE_W-1:0];
            CSR_ALIGN_CURRENT: cfg_in.align_current = csr_wdata[LIMIT_W-1:0];
            CSR_RAMP_STEP:     cfg_in.ramp_step     = csr_wdata[LIMIT_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hw/rtl/olmss_core.sv
// Sequencer state and the per-tick step logic: slews, counters, angle advance.
module olmss_core #(
   parameter int ANGLE_BITS = 13
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                fire,
   input  logic                                restart,
   input  logic signed [olmss_pkg::CUR_W-1:0]  id_request,
   input  logic signed [olmss_pkg::CUR_W-1:0]  iq_request,
   input  olmss_pkg::cfg_type                  cfg,
   output olmss_pkg::result_type               result
);
   import olmss_pkg::*;

   logic [1:0]              stage_ff, stage_in;
   logic [COUNT_W-1:0]      hold_ff, hold_in;
   logic [ANGLE_BITS-1:0]   angle_ff, angle_in;
   logic [ANGLE_W-1:0]      step_ff, step_in;
   logic [COUNT_W-1:0]      div_ff, div_in;
   logic [COUNT_W-1:0]      acc_ff, acc_in;
   logic signed [CUR_W-1:0] id_ff, id_in;
   logic signed [CUR_W-1:0] iq_ff, iq_in;

   logic [ANGLE_W-1:0]      step_tgt;
   logic [COUNT_W-1:0]      acc_per;
   logic [COUNT_W-1:0]      div_per;
   logic signed [CUR_W-1:0] acur;
   logic [COUNT_W-1:0]      acc_inc;
   logic [COUNT_W-1:0]      div_inc;
   logic [ANGLE_W-1:0]      step_acc;
   logic [ANGLE_BITS-1:0]   step_ext;

   assign step_tgt = (cfg.target_step == '0) ? ANGLE_W'(1) : cfg.target_step;
   assign acc_per  = (cfg.accel_ticks == '0) ? COUNT_W'(1) : cfg.accel_ticks;
   assign div_per  = (cfg.step_divider == '0) ? COUNT_W'(1) : cfg.step_divider;
   assign acur     = signed'({1'b0, cfg.align_current});

   always_comb begin
      stage_in = stage_ff;
      hold_in  = hold_ff;
      angle_in = angle_ff;
      step_in  = step_ff;
      div_in   = div_ff;
      acc_in   = acc_ff;
      id_in    = id_ff;
      iq_in    = iq_ff;
      acc_inc  = acc_ff + COUNT_W'(1);
      step_acc = step_ff;

      // Acceleration only runs in the ramp stage
      if (stage_ff == ST_RAMP && step_ff < step_tgt) begin
         if (acc_inc >= acc_per) begin
            step_acc = step_ff + ANGLE_W'(1);
         end
      end
      step_ext = ANGLE_BITS'(step_acc);
      div_inc  = div_ff + COUNT_W'(1);

      if (restart) begin
         stage_in = ST_ALIGN_RAMP;
         hold_in  = '0;
         step_in  = '0;
         div_in   = '0;
         acc_in   = '0;
         id_in    = '0;
         iq_in    = '0;
         angle_in = ANGLE_BITS'(cfg.align_angle);
      end else begin
         case (stage_ff)
            ST_ALIGN_RAMP: begin
               id_in = slew(id_ff, acur, cfg.ramp_step);
               iq_in = '0;
               if (id_in >= acur) begin
                  stage_in = ST_ALIGN_HOLD;
                  hold_in  = '0;
               end
            end
            ST_ALIGN_HOLD: begin
               id_in = acur;
               iq_in = '0;
               // Saturate the hold counter
               if (hold_ff != '1) begin
                  hold_in = hold_ff + COUNT_W'(1);
               end
               if (hold_in >= cfg.hold_ticks) begin
                  stage_in = ST_RAMP;
                  hold_in  = '0;
               end
            end
            ST_RAMP, ST_RUN: begin
               id_in = slew(id_ff, id_request, cfg.ramp_step);
               iq_in = slew(iq_ff, iq_request, cfg.ramp_step);
               if (stage_ff == ST_RAMP && step_ff < step_tgt) begin
                  if (acc_inc >= acc_per) begin
                     acc_in = '0;
                  end else begin
                     acc_in = acc_inc;
                  end
               end
               step_in = step_acc;
               div_in  = div_inc;
               if (div_inc >= div_per && step_acc != '0) begin
                  div_in = '0;
                  if (cfg.reverse_dir) begin
                     angle_in = angle_ff - step_ext;
                  end else begin
                     angle_in = angle_ff + step_ext;
                  end
               end
               if (stage_ff == ST_RAMP && step_acc >= cfg.target_step) begin
                  stage_in = ST_RUN;
               end
            end
            default: begin
               stage_in = stage_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= ST_ALIGN_RAMP;
         hold_ff  <= '0;
         angle_ff <= ANGLE_BITS'(CFG_RESET.align_angle);
         step_ff  <= '0;
         div_ff   <= '0;
         acc_ff   <= '0;
         id_ff    <= '0;
         iq_ff    <= '0;
      end else if (fire) begin
         stage_ff <= stage_in;
         hold_ff  <= hold_in;
         angle_ff <= angle_in;
         step_ff  <= step_in;
         div_ff   <= div_in;
         acc_ff   <= acc_in;
         id_ff    <= id_in;
         iq_ff    <= iq_in;
      end
   end

   // Result reports the state after this tick
   assign result.forced_angle = ANGLE_W'(angle_in);
   assign result.id_ref       = id_in;
   assign result.iq_ref       = iq_in;
   assign result.phase        = stage_in;

`ifndef ASSERT_OFF
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      fire && restart |=> stage_ff == ST_ALIGN_RAMP && id_ff == '0 && step_ff == '0)
      else $error("restart did not clear the sequencer");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(stage_ff) && $stable(angle_ff) && $stable(id_ff))
      else $error("state moved without a transfer");

   a_align_no_q: assert property (@(posedge clock) disable iff (reset)
      stage_ff == ST_ALIGN_RAMP || stage_ff == ST_ALIGN_HOLD |-> iq_ff == '0)
      else $error("q reference nonzero during alignment");

   a_stage_order: assert property (@(posedge clock) disable iff (reset)
      fire && !restart && stage_ff == ST_ALIGN_RAMP |=>
         stage_ff == ST_ALIGN_RAMP || stage_ff == ST_ALIGN_HOLD)
      else $error("align ramp skipped a stage");
`endif

endmodule

>>> hw/rtl/open_loop_motor_startup_sequencer.sv
// Top level of the open-loop forced-angle motor startup sequencer.
// A req transfer reaches rsp valid through the input register, then the result register.
// Throughput: one tick per clock while the rsp side is not stalled; each tick updates the core state registers.
// A stalled rsp side holds one result while the next tick waits in the input register.
// Reset (synchronous, active high) loads the register defaults and starts in align ramp.
module open_loop_motor_startup_sequencer #(
   parameter int ANGLE_BITS = 13
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [31:0]                        req_tdata,  // id_request, iq_request
   input  logic                               req_tuser,  // restart
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [47:0]                        rsp_tdata,  // forced_angle, id_ref, iq_ref, phase
   input  logic                               csr_we,
   input  logic [olmss_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [olmss_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import olmss_pkg::*;

   cfg_type    cfg;
   result_type result;

   logic                    in_v_ff, in_v_in;
   logic signed [CUR_W-1:0] in_id_ff;
   logic signed [CUR_W-1:0] in_iq_ff;
   logic                    in_rst_ff;
   logic                    out_v_ff, out_v_in;
   result_type              out_ff;
   logic                    req_take;
   logic                    fire;

   assign fire       = in_v_ff && (!out_v_ff || rsp_tready);
   assign req_tready = !in_v_ff || fire;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_v_in = in_v_ff;
      if (req_take) begin
         in_v_in = 1'b1;
      end else if (fire) begin
         in_v_in = 1'b0;
      end
      out_v_in = out_v_ff;
      if (fire) begin
         out_v_in = 1'b1;
      end else if (rsp_tready) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         in_v_ff  <= in_v_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_id_ff  <= signed'(req_tdata[15:0]);
         in_iq_ff  <= signed'(req_tdata[31:16]);
         in_rst_ff <= req_tuser;
      end
      if (fire) begin
         out_ff <= result;
      end
   end

   olmss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   olmss_core #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .restart    (in_rst_ff),
      .id_request (in_id_ff),
      .iq_request (in_iq_ff),
      .cfg        (cfg),
      .result     (result)
   );

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {1'b0, out_ff};

`ifndef ASSERT_OFF
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && !rsp_tready |-> !fire)
      else $error("result overwritten while stalled");

   a_fire_sets_valid: assert property (@(posedge clock) disable iff (reset)
      fire |=> out_v_ff)
      else $error("transfer did not produce a result");

   a_take_needs_room: assert property (@(posedge clock) disable iff (reset)
      req_take |-> !in_v_ff || fire)
      else $error("input register overrun");
`endif

endmodule
